// ===== hdl/swr_pkg.sv =====
// ----------------------------------------------------------------------------
// swr_pkg: shared types and constants of the stop-and-wait receiver
// Header layout constants, event codes and the parsed-header struct.
// ----------------------------------------------------------------------------
`default_nettype none

package swr_pkg;

	localparam int unsigned HEADER_WORDS  = 14;
	localparam int unsigned SEGMENT_BYTES = 14820;

	// word positions inside the header
	localparam logic [3:0] W_FLAGS    = 4'd1;
	localparam logic [3:0] W_SEQ      = 4'd8;
	localparam logic [3:0] W_SIZE_HI  = 4'd10;
	localparam logic [3:0] W_SIZE_LO  = 4'd11;
	localparam logic [3:0] W_INDEX    = 4'd12;
	localparam logic [3:0] W_CHECKSUM = 4'(HEADER_WORDS - 1);
	localparam logic [3:0] W_DONE     = 4'(HEADER_WORDS);

	localparam logic [7:0] FIN_BYTE     = 8'h01;
	localparam logic [7:0] TYPE_NAME    = 8'h10;
	localparam logic [7:0] TYPE_CONTENT = 8'h00;
	localparam logic [7:0] TYPE_FINAL   = 8'h01;

	localparam logic [15:0] SUM_GOOD = 16'hFFFF;

	// event codes
	localparam logic [3:0] EV_CONNECT_OK  = 4'd0;
	localparam logic [3:0] EV_CONNECT_BAD = 4'd1;
	localparam logic [3:0] EV_NAME        = 4'd2;
	localparam logic [3:0] EV_CONTENT     = 4'd3;
	localparam logic [3:0] EV_FINAL       = 4'd4;
	localparam logic [3:0] EV_OTHER       = 4'd5;
	localparam logic [3:0] EV_DUPLICATE   = 4'd6;
	localparam logic [3:0] EV_GAP         = 4'd7;
	localparam logic [3:0] EV_BAD         = 4'd8;
	localparam logic [3:0] EV_CLOSE       = 4'd9;
	localparam logic [3:0] EV_CLOSE_REJ   = 4'd10;

	// configuration register indexes
	localparam logic [1:0] REG_SERVER_ADDR = 2'd0;
	localparam logic [1:0] REG_CLIENT_ADDR = 2'd1;
	localparam logic [1:0] REG_SERVER_PORT = 2'd2;
	localparam logic [1:0] REG_CLIENT_PORT = 2'd3;

	// parsed header, valid for one cycle on the checksum word
	typedef struct packed {
		logic        last;
		logic        ok;
		logic        fin;
		logic [7:0]  type_byte;
		logic [15:0] seq;
		logic [15:0] index;
		logic [31:0] size;
	} swr_hdr_t;

	// ones-complement checksum of the reply header's first 13 words
	function automatic logic [15:0] reply_checksum(
		input logic        ack,
		input logic [15:0] num,
		input logic [31:0] srv_addr,
		input logic [31:0] cli_addr,
		input logic [15:0] srv_port,
		input logic [15:0] cli_port
	);
		logic [18:0] raw;
		logic [16:0] fold1;
		logic [15:0] fold2;
		raw = {10'd0, ack, 8'd0} + {3'd0, srv_addr[31:16]} + {3'd0, srv_addr[15:0]}
			+ {3'd0, cli_addr[31:16]} + {3'd0, cli_addr[15:0]}
			+ {3'd0, srv_port} + {3'd0, cli_port} + {3'd0, num};
		fold1 = {1'b0, raw[15:0]} + {14'd0, raw[18:16]};
		fold2 = fold1[15:0] + {15'd0, fold1[16]};
		return ~fold2;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/swr_if.sv =====
// ----------------------------------------------------------------------------
// swr_if: valid/ready channels of the stop-and-wait receiver
// Header word channel in, reply channel out.
// ----------------------------------------------------------------------------
`default_nettype none

interface swr_header_if;
	logic        valid;
	logic        ready;
	logic [15:0] header_word;
	logic        first_word;

	modport source (output valid, header_word, first_word, input ready);
	modport sink   (input valid, header_word, first_word, output ready);
endinterface

interface swr_reply_if;
	logic        valid;
	logic        ready;
	logic        reply_ack;
	logic [15:0] reply_ack_number;
	logic [15:0] reply_checksum;
	logic [3:0]  event_code;
	logic [15:0] payload_index;
	logic [31:0] payload_length;
	logic        send_twice;

	modport source (output valid, reply_ack, reply_ack_number, reply_checksum, event_code,
		payload_index, payload_length, send_twice, input ready);
	modport sink   (input valid, reply_ack, reply_ack_number, reply_checksum, event_code,
		payload_index, payload_length, send_twice, output ready);
endinterface

`default_nettype wire

// ===== hdl/swr_hdr_parse.sv =====
// ----------------------------------------------------------------------------
// swr_hdr_parse: header word counter, running sum and field capture
// Flags the checksum word of each header together with the captured fields.
// ----------------------------------------------------------------------------
`default_nettype none

module swr_hdr_parse import swr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic [15:0] header_word,
	input  wire logic        first_word,
	output swr_hdr_t         hdr
);

	logic [3:0]  count_q;
	logic [15:0] sum_q;
	logic        fin_q;
	logic [7:0]  type_q;
	logic [15:0] seq_q;
	logic [15:0] index_q;
	logic [15:0] size_hi_q;
	logic [15:0] size_lo_q;

	logic [3:0]  pos;
	logic [15:0] sum_base;
	logic [16:0] sum_raw;
	logic [15:0] sum_next;
	logic [16:0] check_raw;

	assign pos      = first_word ? 4'd0 : count_q;
	assign sum_base = first_word ? 16'd0 : sum_q;
	assign sum_raw  = {1'b0, sum_base} + {1'b0, header_word};
	// end-around carry
	assign sum_next = sum_raw[15:0] + {15'd0, sum_raw[16]};
	assign check_raw = {1'b0, header_word} + {1'b0, sum_q};

	always_comb begin
		hdr.last      = accept && (pos == W_CHECKSUM);
		hdr.ok        = (check_raw == {1'b0, SUM_GOOD});
		hdr.fin       = fin_q;
		hdr.type_byte = type_q;
		hdr.seq       = seq_q;
		hdr.index     = index_q;
		hdr.size      = {size_hi_q, size_lo_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= 4'd0;
			sum_q     <= 16'd0;
			fin_q     <= 1'b0;
			type_q    <= 8'd0;
			seq_q     <= 16'd0;
			index_q   <= 16'd0;
			size_hi_q <= 16'd0;
			size_lo_q <= 16'd0;
		end else if (accept) begin
			if (pos < W_CHECKSUM) begin
				sum_q   <= sum_next;
				count_q <= pos + 4'd1;
				case (pos)
					W_FLAGS: begin
						fin_q  <= (header_word[15:8] == FIN_BYTE);
						type_q <= header_word[7:0];
					end
					W_SEQ:     seq_q     <= header_word;
					W_SIZE_HI: size_hi_q <= header_word;
					W_SIZE_LO: size_lo_q <= header_word;
					W_INDEX:   index_q   <= header_word;
					default:   ;
				endcase
			end else if (pos == W_CHECKSUM) begin
				count_q <= W_DONE;
			end else if (first_word) begin
				// unreachable: a first word always lands at position zero
				count_q <= 4'd0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/stop_and_wait_receiver.sv =====
// ----------------------------------------------------------------------------
// stop_and_wait_receiver: stop-and-wait ARQ receiver, header path
// Parses 14-word headers, checks the checksum, runs the connect, data and
// teardown phases and builds at most one reply per completed header.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  header  | in  | valid/ready          | header_word, first_word
//  reply   | out | valid/ready          | ack, ack number, checksum, event, ...
//  apb     | in  | psel/penable/pready  | paddr[3:0], pwdata/prdata 32 bits
//
//  One header word is taken per cycle; the reply for a header is registered
//  on the edge that takes its checksum word and shows on the next cycle.
//  The single reply register sets the rate: a word is taken while the reply
//  register is empty or being drained in the same cycle.
//  Reset puts the block in the connect phase with the word count at zero.
// ----------------------------------------------------------------------------
`default_nettype none

module stop_and_wait_receiver import swr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	swr_header_if.sink       header,
	swr_reply_if.source      reply,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	localparam logic [1:0] PH_CONNECT  = 2'd0;
	localparam logic [1:0] PH_DATA     = 2'd1;
	localparam logic [1:0] PH_TEARDOWN = 2'd2;
	localparam logic [1:0] PH_DONE     = 2'd3;

	logic [31:0] srv_addr_q;
	logic [31:0] cli_addr_q;
	logic [15:0] srv_port_q;
	logic [15:0] cli_port_q;

	logic [1:0]  phase_q;
	logic [15:0] last_seq_q;
	logic        prev_ack_q;
	logic [15:0] prev_num_q;

	logic        out_valid_q;
	logic        out_ack_q;
	logic [15:0] out_num_q;
	logic [15:0] out_sum_q;
	logic [3:0]  out_ev_q;
	logic [15:0] out_idx_q;
	logic [31:0] out_len_q;
	logic        out_twice_q;

	logic        accept;
	swr_hdr_t    hdr;

	logic        emit;
	logic        e_ack;
	logic [15:0] e_num;
	logic [3:0]  e_ev;
	logic [15:0] e_idx;
	logic [31:0] e_len;
	logic        e_twice;
	logic [1:0]  phase_next;
	logic        take_seq;
	logic [16:0] seq_expect;

	// configuration port
	logic       cfg_we;
	logic [1:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite;
	assign cfg_idx = paddr[3:2];

	always_comb begin
		case (cfg_idx)
			REG_SERVER_ADDR: prdata = srv_addr_q;
			REG_CLIENT_ADDR: prdata = cli_addr_q;
			REG_SERVER_PORT: prdata = {16'd0, srv_port_q};
			REG_CLIENT_PORT: prdata = {16'd0, cli_port_q};
			default:         prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srv_addr_q <= 32'h7F00_0001;
			cli_addr_q <= 32'h7F00_0001;
			srv_port_q <= 16'd4000;
			cli_port_q <= 16'd5678;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SERVER_ADDR: srv_addr_q <= pwdata;
				REG_CLIENT_ADDR: cli_addr_q <= pwdata;
				REG_SERVER_PORT: srv_port_q <= pwdata[15:0];
				REG_CLIENT_PORT: cli_port_q <= pwdata[15:0];
				default:         ;
			endcase
		end
	end

	// take a word while the reply register is free or draining
	assign header.ready = !out_valid_q || reply.ready;
	assign accept       = header.valid && header.ready;

	swr_hdr_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.header_word (header.header_word),
		.first_word  (header.first_word),
		.hdr         (hdr)
	);

	// in order means exactly one above, no wrap
	assign seq_expect = {1'b0, last_seq_q} + 17'd1;

	always_comb begin
		emit       = 1'b0;
		e_ack      = 1'b0;
		e_num      = hdr.seq;
		e_ev       = EV_OTHER;
		e_idx      = 16'd0;
		e_len      = 32'd0;
		e_twice    = 1'b0;
		phase_next = phase_q;
		take_seq   = 1'b0;
		case (phase_q)
			PH_CONNECT: begin
				emit = 1'b1;
				if (hdr.ok) begin
					e_ack      = 1'b1;
					e_ev       = EV_CONNECT_OK;
					phase_next = PH_DATA;
					take_seq   = 1'b1;
				end else begin
					e_ev = EV_CONNECT_BAD;
				end
			end
			PH_DATA: begin
				if (hdr.fin) begin
					phase_next = PH_TEARDOWN;
				end else if (!hdr.ok) begin
					emit  = 1'b1;
					e_num = prev_num_q;
					e_ev  = EV_BAD;
				end else if ({1'b0, hdr.seq} == seq_expect) begin
					emit     = 1'b1;
					e_ack    = 1'b1;
					take_seq = 1'b1;
					case (hdr.type_byte)
						TYPE_NAME: begin
							e_ev  = EV_NAME;
							e_len = hdr.size;
						end
						TYPE_CONTENT: begin
							e_ev  = EV_CONTENT;
							e_idx = hdr.index;
							e_len = 32'(SEGMENT_BYTES);
						end
						TYPE_FINAL: begin
							e_ev  = EV_FINAL;
							e_idx = hdr.index;
							e_len = hdr.size;
						end
						default: e_ev = EV_OTHER;
					endcase
				end else if (hdr.seq <= last_seq_q) begin
					emit  = 1'b1;
					e_ack = 1'b1;
					e_ev  = EV_DUPLICATE;
				end else begin
					// gap: repeat the previous reply
					emit  = 1'b1;
					e_ack = prev_ack_q;
					e_num = prev_num_q;
					e_ev  = EV_GAP;
				end
			end
			PH_TEARDOWN: begin
				emit = 1'b1;
				if (hdr.fin && hdr.ok) begin
					e_ack      = 1'b1;
					e_ev       = EV_CLOSE;
					e_twice    = 1'b1;
					phase_next = PH_DONE;
				end else begin
					e_ev = EV_CLOSE_REJ;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_CONNECT;
			last_seq_q <= 16'd0;
			prev_ack_q <= 1'b0;
			prev_num_q <= 16'd0;
		end else if (hdr.last) begin
			phase_q <= phase_next;
			if (take_seq) begin
				last_seq_q <= hdr.seq;
			end
			if (emit) begin
				prev_ack_q <= e_ack;
				prev_num_q <= e_num;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (hdr.last && emit) begin
			out_valid_q <= 1'b1;
		end else if (reply.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the payload until the next reply is loaded
	always_ff @(posedge clk) begin
		if (hdr.last && emit) begin
			out_ack_q   <= e_ack;
			out_num_q   <= e_num;
			out_sum_q   <= reply_checksum(e_ack, e_num, srv_addr_q, cli_addr_q,
				srv_port_q, cli_port_q);
			out_ev_q    <= e_ev;
			out_idx_q   <= e_idx;
			out_len_q   <= e_len;
			out_twice_q <= e_twice;
		end
	end

	assign reply.valid            = out_valid_q;
	assign reply.reply_ack        = out_ack_q;
	assign reply.reply_ack_number = out_num_q;
	assign reply.reply_checksum   = out_sum_q;
	assign reply.event_code       = out_ev_q;
	assign reply.payload_index    = out_idx_q;
	assign reply.payload_length   = out_len_q;
	assign reply.send_twice       = out_twice_q;

endmodule

`default_nettype wire
